### hdl/nta_pkg.sv
// ----------------------------------------------------------------------------
// nta_pkg
// Types and constants shared by the neighbor table blocks.
// ----------------------------------------------------------------------------
package nta_pkg;

	// result status codes
	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_REFRESHED = 3'd1;
	localparam logic [2:0] ST_SHORT     = 3'd2;
	localparam logic [2:0] ST_BAD_PORT  = 3'd3;
	localparam logic [2:0] ST_OWN_ID    = 3'd4;
	localparam logic [2:0] ST_FULL      = 3'd5;
	localparam logic [2:0] ST_PURGED    = 3'd6;

	// register indexes, taken from paddr[2]
	localparam logic REG_OWN_ID  = 1'b0;
	localparam logic REG_MAX_AGE = 1'b1;

	localparam logic [15:0] MAX_AGE_RESET = 16'd1200;
	localparam logic [7:0]  MIN_PAYLOAD   = 8'd2;
	localparam int          ADDR_W        = 3;

	typedef struct packed {
		logic        action;
		logic [15:0] node_id;
		logic [7:0]  rx_port;
		logic [7:0]  msg_len;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [4:0] live_count;
		logic [4:0] port_count_0;
		logic [4:0] port_count_1;
		logic [4:0] port_count_2;
		logic [4:0] port_count_3;
	} result_t;

	typedef struct packed {
		logic [15:0] own_id;
		logic [15:0] max_age;
	} cfg_t;

endpackage

### hdl/neighbor_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top
// Neighbor table with heartbeat refresh and age based eviction on ticks.
//
//   channel   direction  handshake             beat
//   item      in         item_valid/item_stall one heartbeat or tick
//   result    out        result_valid/stall    status, live and port counts
//   apb       in/out     psel/penable/pready   own id, max age
//
// work between the accepting edge and the edge that loads the output register:
// a rejected heartbeat goes straight to done; a refresh stops at the matching entry;
// a new or dropped id is compared with every live entry, one entry compared per cycle
// tick: walks every live entry from the top down, plus a swap fetch for each evicted
// entry below the current last; the engine is idle again from that loading edge
// reset empties the table at once; item_stall is high while an item is in
// work or its result waits in the engine behind a stalled output register
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top #(
	parameter int TABLE_DEPTH = 20,
	parameter int RX_PORTS    = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nta_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  nta_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output nta_pkg::result_t            result
);
	import nta_pkg::*;

	cfg_t    cfg;
	result_t eng_res;
	result_t result_q;
	logic    result_valid_q;
	logic    eng_idle;
	logic    eng_res_valid;
	logic    start;
	logic    take;

	nta_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nta_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.RX_PORTS    (RX_PORTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.start     (start),
		.item      (item),
		.take      (take),
		.idle      (eng_idle),
		.res_valid (eng_res_valid),
		.res       (eng_res)
	);

	assign item_stall = !eng_idle;
	assign start      = item_valid && eng_idle;
	// output slot frees up when empty or when its beat leaves this cycle
	assign take       = eng_res_valid && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= eng_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	logic [6:0] port_sum;

	assign port_sum = 7'(result.port_count_0) + 7'(result.port_count_1)
		+ 7'(result.port_count_2) + 7'(result.port_count_3);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("engine idle right after accepting an item");

	a_port_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (RX_PORTS > 4) || (TABLE_DEPTH > 31)
			|| (port_sum == 7'(result.live_count)))
		else $error("port counts do not add up to the live count");

	a_added_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_ADDED) |->
			(TABLE_DEPTH > 31) || (result.live_count != '0))
		else $error("entry added but table reported empty");

endmodule

### hdl/nta_cfg.sv
// ----------------------------------------------------------------------------
// nta_cfg
// APB register file holding own id and maximum age.
// ----------------------------------------------------------------------------
module nta_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [nta_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output nta_pkg::cfg_t               cfg
);
	import nta_pkg::*;

	logic [15:0] own_id_q;
	logic [15:0] max_age_q;
	logic        wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q  <= '0;
			max_age_q <= MAX_AGE_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_OWN_ID: begin
					own_id_q <= pwdata[15:0];
				end
				REG_MAX_AGE: begin
					max_age_q <= pwdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OWN_ID: begin
				prdata = {16'd0, own_id_q};
			end
			REG_MAX_AGE: begin
				prdata = {16'd0, max_age_q};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

	assign cfg.own_id  = own_id_q;
	assign cfg.max_age = max_age_q;

endmodule

### hdl/nta_engine.sv
// ----------------------------------------------------------------------------
// nta_engine
// Table memory, sequencer for search, append and purge, and port counters.
// ----------------------------------------------------------------------------
module nta_engine #(
	parameter int TABLE_DEPTH = 20,
	parameter int RX_PORTS    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nta_pkg::cfg_t      cfg,
	input  logic               start,
	input  nta_pkg::item_t     item,
	input  logic               take,
	output logic               idle,
	output logic               res_valid,
	output nta_pkg::result_t   res
);
	import nta_pkg::*;

	localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int PORT_W = (RX_PORTS > 1) ? $clog2(RX_PORTS) : 1;

	typedef struct packed {
		logic [15:0]       id;
		logic [31:0]       seen;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_CHECK  = 5'b00100,
		S_MOVE   = 5'b01000,
		S_DONE   = 5'b10000
	} state_t;

	entry_t entry_mem [TABLE_DEPTH];
	entry_t rd_data_q;
	entry_t wr_data;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic             wr_en;

	state_t            state_q, state_d;
	logic [2:0]        status_q, status_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  iss_q, iss_d;
	logic              cmp_vld_q, cmp_vld_d;
	logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
	logic [IDX_W-1:0]  k_q, k_d;
	logic [15:0]       sender_q, sender_d;
	logic [PORT_W-1:0] port_q, port_d;
	logic [31:0]       now_q, now_d;
	logic [CNT_W-1:0]  port_cnt_q [RX_PORTS];

	logic              inc_en;
	logic              dec_en;
	logic [PORT_W-1:0] dec_port;
	logic [31:0]       age;
	logic              stale;
	logic              k_is_last;
	logic              hit;
	logic              adv;

	assign age       = now_q - rd_data_q.seen;
	assign stale     = age > {16'd0, cfg.max_age};
	assign k_is_last = (CNT_W'(k_q) == count_q - CNT_W'(1));
	assign hit       = cmp_vld_q && (rd_data_q.id == sender_q);

	always_comb begin
		state_d   = state_q;
		status_d  = status_q;
		count_d   = count_q;
		iss_d     = iss_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		k_d       = k_q;
		sender_d  = sender_q;
		port_d    = port_q;
		now_d     = now_q;
		rd_addr   = IDX_W'(iss_q);
		wr_en     = 1'b0;
		wr_addr   = cmp_idx_q;
		wr_data   = '{id: sender_q, seen: now_q, port: port_q};
		inc_en    = 1'b0;
		dec_en    = 1'b0;
		dec_port  = rd_data_q.port;
		adv       = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					sender_d  = item.node_id;
					port_d    = PORT_W'(item.rx_port);
					now_d     = item.now_ms;
					iss_d     = '0;
					cmp_vld_d = 1'b0;
					if (item.action) begin
						status_d = ST_PURGED;
						if (count_q == '0) begin
							state_d = S_DONE;
						end else begin
							// first read of the walk from the top entry down
							k_d     = IDX_W'(count_q - CNT_W'(1));
							rd_addr = IDX_W'(count_q - CNT_W'(1));
							state_d = S_CHECK;
						end
					end else if (item.msg_len < MIN_PAYLOAD) begin
						status_d = ST_SHORT;
						state_d  = S_DONE;
					end else if (item.rx_port >= 8'(RX_PORTS)) begin
						status_d = ST_BAD_PORT;
						state_d  = S_DONE;
					end else if (item.node_id == cfg.own_id) begin
						status_d = ST_OWN_ID;
						state_d  = S_DONE;
					end else begin
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				if (hit) begin
					wr_en    = 1'b1;
					wr_addr  = cmp_idx_q;
					inc_en   = 1'b1;
					dec_en   = 1'b1;
					status_d = ST_REFRESHED;
					state_d  = S_DONE;
				end else if (!cmp_vld_q && (iss_q == count_q)) begin
					// every entry compared, no match
					if (count_q >= CNT_W'(TABLE_DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						wr_en    = 1'b1;
						wr_addr  = IDX_W'(count_q);
						inc_en   = 1'b1;
						count_d  = count_q + CNT_W'(1);
						status_d = ST_ADDED;
					end
					state_d = S_DONE;
				end else if (iss_q != count_q) begin
					rd_addr   = IDX_W'(iss_q);
					iss_d     = iss_q + CNT_W'(1);
					cmp_vld_d = 1'b1;
					cmp_idx_d = IDX_W'(iss_q);
				end else begin
					cmp_vld_d = 1'b0;
				end
			end
			S_CHECK: begin
				if (stale) begin
					dec_en  = 1'b1;
					count_d = count_q - CNT_W'(1);
					if (!k_is_last) begin
						// fetch the last entry to fill the freed slot
						rd_addr = IDX_W'(count_q - CNT_W'(1));
						state_d = S_MOVE;
					end else begin
						adv = 1'b1;
					end
				end else begin
					adv = 1'b1;
				end
			end
			S_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
				wr_data = rd_data_q;
				adv     = 1'b1;
			end
			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (adv) begin
			if (k_q == '0) begin
				state_d = S_DONE;
			end else begin
				k_d     = k_q - IDX_W'(1);
				rd_addr = k_q - IDX_W'(1);
				state_d = S_CHECK;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= entry_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			iss_q     <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			iss_q     <= iss_d;
			cmp_vld_q <= cmp_vld_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q  <= status_d;
		cmp_idx_q <= cmp_idx_d;
		k_q       <= k_d;
		sender_q  <= sender_d;
		port_q    <= port_d;
		now_q     <= now_d;
	end

	// a refresh on the same port cancels its own increment and decrement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < RX_PORTS; p++) begin
				port_cnt_q[p] <= '0;
			end
		end else begin
			for (int p = 0; p < RX_PORTS; p++) begin
				port_cnt_q[p] <= port_cnt_q[p]
					+ CNT_W'(inc_en && (port_q == PORT_W'(p)))
					- CNT_W'(dec_en && (dec_port == PORT_W'(p)));
			end
		end
	end

	logic [4:0] rep_cnt [4];

	for (genvar i = 0; i < 4; i++) begin : g_rep
		if (i < RX_PORTS) begin : g_live
			assign rep_cnt[i] = 5'(port_cnt_q[i]);
		end else begin : g_none
			assign rep_cnt[i] = '0;
		end
	end

	assign idle             = (state_q == S_IDLE);
	assign res_valid        = (state_q == S_DONE);
	assign res.status       = status_q;
	assign res.live_count   = 5'(count_q);
	assign res.port_count_0 = rep_cnt[0];
	assign res.port_count_1 = rep_cnt[1];
	assign res.port_count_2 = rep_cnt[2];
	assign res.port_count_3 = rep_cnt[3];

endmodule

### tb/neighbor_table_with_aging_top_test.sv
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_top_test
// Self-checking bench for the neighbor table. It drives heartbeats and ticks
// through the item channel and keeps its own copy of the table to predict
// each status and count report. Random sender gaps and receiver stalls are
// applied. Own id and max age are changed between phases over the APB port.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import nta_pkg::*;

	localparam int DEPTH = 20;
	localparam int PORTS = 4;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_style_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                item_valid = 1'b0;
	logic                item_stall;
	item_t               item = '0;
	logic                result_valid;
	logic                result_stall = 1'b0;
	result_t             result;

	// shadow of the neighbor table and registers
	logic [15:0] nb_id [DEPTH];
	logic [31:0] nb_seen [DEPTH];
	logic [7:0]  nb_port [DEPTH];
	int          nb_live;
	logic [15:0] own_id_cfg;
	logic [15:0] max_age_cfg;

	result_t      reports [$];
	result_t      want;
	int           fails = 0;
	bit           bursty = 1'b0;
	int           burst_left = 0;
	stall_style_t stall_style = STALL_NONE;
	bit           stall_on = 1'b0;
	int           stall_run = 0;
	logic [31:0]  wall_ms = '0;

	neighbor_table_with_aging_top #(
		.TABLE_DEPTH(DEPTH),
		.RX_PORTS(PORTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// applies one beat to the shadow table and returns the report it should produce
	function automatic result_t table_update(input item_t it);
		result_t     r;
		logic [2:0]  st;
		logic [31:0] age;
		int          k;
		int          last;
		int          hit;
		int          cnt [4];
		if (it.action) begin
			st = ST_PURGED;
			for (k = nb_live - 1; k >= 0; k--) begin
				age = it.now_ms - nb_seen[k];
				if (age > {16'd0, max_age_cfg}) begin
					last = nb_live - 1;
					nb_id[k] = nb_id[last];
					nb_seen[k] = nb_seen[last];
					nb_port[k] = nb_port[last];
					nb_live = last;
				end
			end
		end else if (it.msg_len < MIN_PAYLOAD) begin
			st = ST_SHORT;
		end else if (it.rx_port >= PORTS) begin
			st = ST_BAD_PORT;
		end else if (it.node_id == own_id_cfg) begin
			st = ST_OWN_ID;
		end else begin
			hit = -1;
			for (k = 0; k < nb_live; k++)
				if (hit < 0 && nb_id[k] == it.node_id) hit = k;
			if (hit >= 0) begin
				nb_seen[hit] = it.now_ms;
				nb_port[hit] = it.rx_port;
				st = ST_REFRESHED;
			end else if (nb_live >= DEPTH) begin
				st = ST_FULL;
			end else begin
				nb_id[nb_live] = it.node_id;
				nb_seen[nb_live] = it.now_ms;
				nb_port[nb_live] = it.rx_port;
				nb_live++;
				st = ST_ADDED;
			end
		end
		for (k = 0; k < 4; k++) cnt[k] = 0;
		for (k = 0; k < nb_live; k++)
			if (nb_port[k] < 4) cnt[nb_port[k]]++;
		r.status = st;
		r.live_count = nb_live[4:0];
		r.port_count_0 = cnt[0][4:0];
		r.port_count_1 = cnt[1][4:0];
		r.port_count_2 = cnt[2][4:0];
		r.port_count_3 = cnt[3][4:0];
		return r;
	endfunction

	function automatic item_t mk_hb(input logic [15:0] id, input logic [7:0] port,
			input logic [7:0] len, input logic [31:0] now);
		item_t it;
		it.action = 1'b0;
		it.node_id = id;
		it.rx_port = port;
		it.msg_len = len;
		it.now_ms = now;
		return it;
	endfunction

	// a tick ignores id, port and length, so those carry junk
	function automatic item_t mk_tick(input logic [31:0] now);
		item_t it;
		it.action = 1'b1;
		it.node_id = 16'($urandom_range(0, 65535));
		it.rx_port = 8'($urandom_range(0, 255));
		it.msg_len = 8'($urandom_range(0, 255));
		it.now_ms = now;
		return it;
	endfunction

	task automatic check_field(input string name, input logic [4:0] exp_v,
			input logic [4:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (reports.size() == 0) begin
				$display("%0t: result beat with none expected, actual %p", $time, result);
				fails++;
			end else begin
				want = reports.pop_front();
				check_field("status", {2'b0, want.status}, {2'b0, result.status});
				check_field("live_count", want.live_count, result.live_count);
				check_field("port_count_0", want.port_count_0, result.port_count_0);
				check_field("port_count_1", want.port_count_1, result.port_count_1);
				check_field("port_count_2", want.port_count_2, result.port_count_2);
				check_field("port_count_3", want.port_count_3, result.port_count_3);
			end
		end
	end

	always @(posedge clk) begin
		case (stall_style)
			STALL_NONE: begin
				result_stall <= 1'b0;
			end
			STALL_LIGHT: begin
				result_stall <= ($urandom_range(0, 3) == 0);
			end
			STALL_RUNS: begin
				if (stall_run == 0) begin
					stall_on = !stall_on;
					stall_run = stall_on ? $urandom_range(1, 15) : $urandom_range(1, 10);
				end else begin
					stall_run--;
				end
				result_stall <= stall_on;
			end
			default: begin
				result_stall <= ($urandom_range(0, 9) < 6);
			end
		endcase
	end

	task automatic send_item(input item_t it);
		int gap;
		if (bursty && burst_left == 0) begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (bursty) burst_left--;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		reports.push_back(table_update(it));
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		while (reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_OWN_ID) own_id_cfg = val;
		else max_age_cfg = val;
		@(posedge clk);
	endtask

	task automatic reg_check(input logic idx);
		logic [15:0] exp_v;
		exp_v = (idx == REG_OWN_ID) ? own_id_cfg : max_age_cfg;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== exp_v) begin
			$display("%0t: register %0d readback, expected %h, actual %h",
				$time, idx, exp_v, prdata[15:0]);
			fails++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [15:0] own, input logic [15:0] age);
		wait_drained();
		reg_write(REG_OWN_ID, own);
		reg_write(REG_MAX_AGE, age);
	endtask

	task automatic run_traffic(input int count, input int pool_size, input bit pause_midway);
		logic [15:0] pool [$];
		logic [15:0] id;
		item_t       it;
		int          i;
		int          r;
		int          t;
		pool = {};
		repeat (pool_size) pool.push_back(16'($urandom_range(0, 65535)));
		if ($urandom_range(0, 1)) pool[0] = own_id_cfg;
		for (i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) wait_drained();
			t = $urandom_range(0, 99);
			if (t < 3) wall_ms = $urandom();
			else if (t < 20) wall_ms += $urandom_range(0, 2 * int'(max_age_cfg) + 2);
			else wall_ms += $urandom_range(0, int'(max_age_cfg) / 8 + 3);
			id = pool[$urandom_range(0, pool.size() - 1)];
			r = $urandom_range(0, 99);
			if (r < 62)
				it = mk_hb(id, 8'($urandom_range(0, PORTS - 1)), 8'($urandom_range(2, 255)),
					wall_ms);
			else if (r < 68)
				it = mk_hb(16'($urandom_range(0, 65535)), 8'($urandom_range(0, PORTS - 1)),
					8'($urandom_range(2, 255)), wall_ms);
			else if (r < 82)
				it = mk_tick(wall_ms);
			else if (r < 87)
				it = mk_hb(id, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 1)), wall_ms);
			else if (r < 93)
				it = mk_hb(id, 8'($urandom_range(PORTS, 255)), 8'($urandom_range(2, 255)),
					wall_ms);
			else
				it = mk_hb(own_id_cfg, 8'($urandom_range(0, PORTS - 1)),
					8'($urandom_range(2, 255)), wall_ms);
			send_item(it);
		end
	endtask

	task automatic test_registers();
		stall_style = STALL_NONE;
		reg_check(REG_OWN_ID);
		reg_check(REG_MAX_AGE);
		reg_write(REG_OWN_ID, 16'hFFFF);
		reg_write(REG_MAX_AGE, 16'h0000);
		reg_check(REG_OWN_ID);
		reg_check(REG_MAX_AGE);
		reg_write(REG_MAX_AGE, 16'hFFFF);
		reg_check(REG_MAX_AGE);
	endtask

	task automatic test_checks_and_aging();
		logic [31:0] t0;
		t0 = 32'd1000;
		configure(16'h1234, 16'd1200);
		bursty = 1'b0;
		stall_style = STALL_LIGHT;
		// rejection order: length first, then port, then own id
		send_item(mk_hb(16'h0001, 8'd0, 8'd1, t0));
		send_item(mk_hb(16'h1234, 8'd255, 8'd0, t0));
		send_item(mk_hb(16'h1234, 8'd4, 8'd2, t0));
		send_item(mk_hb(16'hFFFF, 8'd255, 8'd255, t0));
		send_item(mk_hb(16'h1234, 8'd3, 8'd2, t0));
		send_item(mk_hb(16'h0000, 8'd0, 8'd2, t0));
		send_item(mk_hb(16'hFFFF, 8'd1, 8'd255, t0));
		send_item(mk_hb(16'h00AA, 8'd2, 8'd2, t0));
		send_item(mk_hb(16'h5555, 8'd3, 8'd200, t0));
		// refresh moves the entry to another port
		send_item(mk_hb(16'h0000, 8'd3, 8'd2, t0 + 100));
		// age equal to max age stays, one more ms evicts
		send_item(mk_tick(t0 + 1200));
		send_item(mk_tick(t0 + 1201));
		send_item(mk_tick(t0 + 1201));
		// age taken across the 32-bit wrap
		send_item(mk_hb(16'hBEEF, 8'd1, 8'd2, 32'hFFFF_FF00));
		send_item(mk_tick(32'h0000_0100));
		send_item(mk_hb(16'h0000, 8'd2, 8'd3, 32'hFFFF_FFFF));
		send_item(mk_tick(32'h0000_0500));
		send_item(mk_tick(32'h0000_0500));
		wait_drained();
	endtask

	task automatic test_table_fill_and_refresh();
		configure(16'($urandom_range(0, 65535)), 16'd1200);
		bursty = 1'b1;
		stall_style = STALL_LIGHT;
		wall_ms = $urandom();
		run_traffic(110, 24, 1'b0);
	endtask

	task automatic test_zero_max_age();
		configure(16'h0000, 16'h0000);
		bursty = 1'b0;
		stall_style = STALL_NONE;
		run_traffic(100, 10, 1'b0);
	endtask

	task automatic test_max_values();
		configure(16'hFFFF, 16'hFFFF);
		bursty = 1'b1;
		stall_style = STALL_RUNS;
		run_traffic(110, 28, 1'b1);
	endtask

	task automatic test_time_wrap();
		configure(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 300)));
		bursty = 1'b1;
		stall_style = STALL_HEAVY;
		wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
		run_traffic(110, 22, 1'b0);
	endtask

	task automatic test_random_mix();
		configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		bursty = 1'b1;
		stall_style = STALL_LIGHT;
		run_traffic(100, 25, 1'b0);
	endtask

	initial begin
		nb_live = 0;
		own_id_cfg = 16'h0000;
		max_age_cfg = MAX_AGE_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_registers();
		test_checks_and_aging();
		test_table_fill_and_refresh();
		test_zero_max_age();
		test_max_values();
		test_time_wrap();
		test_random_mix();
		wait_drained();
		repeat (48) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
